// ===== hw/rtl/sipnict_pkg.sv =====
// Types and constants for the SIP client non-INVITE transaction block.
// Used by sipnict_core, sipnict_emit and the top level; no dependencies.
package sipnict_pkg;

    localparam int ACT_W    = 3;
    localparam int TID_W    = 2;
    localparam int TVAL_W   = 22;
    localparam int CODE_W   = 10;
    localparam int EV_W     = 3;
    localparam int IVL_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_ACTS = 4;
    localparam int CNT_W    = 3;
    localparam int SEL_W    = 2;

    // Timer F multiplier is 64, a shift by six.
    localparam int F_SHIFT  = 6;

    localparam logic [CODE_W-1:0] TIMEOUT_CODE   = CODE_W'(408);
    localparam logic [CODE_W-1:0] TRANSPORT_CODE = CODE_W'(503);

    localparam logic [IVL_W-1:0] T1_RESET = IVL_W'(500);
    localparam logic [IVL_W-1:0] T2_RESET = IVL_W'(4000);
    localparam logic [IVL_W-1:0] T4_RESET = IVL_W'(5000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_T1 = 2'd0,
        REG_T2 = 2'd1,
        REG_T4 = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_TRYING     = 3'd1,
        PH_PROCEEDING = 3'd2,
        PH_COMPLETED  = 3'd3,
        PH_TERMINATED = 3'd4
    } phase_t;

    typedef enum logic [EV_W-1:0] {
        EV_SEND      = 3'd0,
        EV_PROV      = 3'd1,
        EV_FINAL     = 3'd2,
        EV_TRANS_ERR = 3'd3,
        EV_TIMER_E   = 3'd4,
        EV_TIMER_F   = 3'd5,
        EV_TIMER_K   = 3'd6
    } event_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_TRANSMIT = 3'd0,
        ACT_START    = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_DELIVER  = 3'd3,
        ACT_RELEASE  = 3'd4
    } act_code_t;

    typedef enum logic [TID_W-1:0] {
        TMR_E = 2'd0,
        TMR_F = 2'd1,
        TMR_K = 2'd2
    } timer_t;

    typedef struct packed {
        act_code_t          action;
        timer_t             timer_id;
        logic [TVAL_W-1:0]  timer_value;
        logic [CODE_W-1:0]  status_code;
    } act_t;

    // One event's run of actions; only the first cnt entries are meaningful.
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        act_t [MAX_ACTS-1:0]   acts;
    } bundle_t;

    function automatic act_t mk_act(act_code_t a, timer_t t,
                                    logic [TVAL_W-1:0] v, logic [CODE_W-1:0] c);
        act_t r;
        r.action      = a;
        r.timer_id    = t;
        r.timer_value = v;
        r.status_code = c;
        return r;
    endfunction

endpackage

// ===== hw/rtl/sipnict_core.sv =====
// Transaction phase and retransmit interval registers plus event decode.
// Depends on sipnict_pkg; produces one action bundle per decoded event.
module sipnict_core
    import sipnict_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [EV_W-1:0]      req_type,
    input  logic [CODE_W-1:0]    response_code,
    input  logic [IVL_W-1:0]     t1,
    input  logic [IVL_W-1:0]     t2,
    input  logic [IVL_W-1:0]     t4,
    output bundle_t              bundle
);

    phase_t            phase_reg, phase_next;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;
    logic              active;
    logic [IVL_W:0]    dbl;
    logic [IVL_W-1:0]  e_ivl;
    logic [TVAL_W-1:0] zero_v;
    logic [CODE_W-1:0] zero_c;

    // Hold phase and interval; update only when an event is decoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ivl_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            ivl_reg   <= ivl_next;
        end
    end

    // Next timer E interval: double and cap at T2 in trying, T2 in proceeding.
    always_comb begin
        dbl = {ivl_reg, 1'b0};
        if (phase_reg == PH_TRYING) begin
            e_ivl = (dbl < {1'b0, t2}) ? dbl[IVL_W-1:0] : t2;
        end else begin
            e_ivl = t2;
        end
    end

    // Decode the event against the current phase into a run of actions.
    always_comb begin
        zero_v     = '0;
        zero_c     = '0;
        active     = (phase_reg == PH_TRYING) || (phase_reg == PH_PROCEEDING);
        phase_next = phase_reg;
        ivl_next   = ivl_reg;
        bundle     = '0;
        case (req_type)
            EV_SEND: begin
                if (phase_reg == PH_IDLE) begin
                    phase_next     = PH_TRYING;
                    ivl_next       = t1;
                    bundle.cnt     = CNT_W'(3);
                    bundle.acts[0] = mk_act(ACT_TRANSMIT, TMR_E, zero_v, zero_c);
                    bundle.acts[1] = mk_act(ACT_START, TMR_E,
                                            TVAL_W'(t1), zero_c);
                    bundle.acts[2] = mk_act(ACT_START, TMR_F,
                                            TVAL_W'(t1) << F_SHIFT, zero_c);
                end
            end
            EV_PROV: begin
                if (active) begin
                    phase_next     = PH_PROCEEDING;
                    bundle.cnt     = CNT_W'(1);
                    bundle.acts[0] = mk_act(ACT_DELIVER, TMR_E, zero_v,
                                            response_code);
                end
            end
            EV_FINAL: begin
                if (active) begin
                    phase_next     = PH_COMPLETED;
                    bundle.cnt     = CNT_W'(4);
                    bundle.acts[0] = mk_act(ACT_START, TMR_K,
                                            TVAL_W'(t4), zero_c);
                    bundle.acts[1] = mk_act(ACT_STOP, TMR_E, zero_v, zero_c);
                    bundle.acts[2] = mk_act(ACT_STOP, TMR_F, zero_v, zero_c);
                    bundle.acts[3] = mk_act(ACT_DELIVER, TMR_E, zero_v,
                                            response_code);
                end
            end
            EV_TRANS_ERR: begin
                if (active) begin
                    phase_next     = PH_TERMINATED;
                    bundle.cnt     = CNT_W'(4);
                    bundle.acts[0] = mk_act(ACT_STOP, TMR_E, zero_v, zero_c);
                    bundle.acts[1] = mk_act(ACT_STOP, TMR_F, zero_v, zero_c);
                    bundle.acts[2] = mk_act(ACT_DELIVER, TMR_E, zero_v,
                                            TRANSPORT_CODE);
                    bundle.acts[3] = mk_act(ACT_RELEASE, TMR_E, zero_v, zero_c);
                end
            end
            EV_TIMER_E: begin
                if (active) begin
                    ivl_next       = e_ivl;
                    bundle.cnt     = CNT_W'(2);
                    bundle.acts[0] = mk_act(ACT_START, TMR_E,
                                            TVAL_W'(e_ivl), zero_c);
                    bundle.acts[1] = mk_act(ACT_TRANSMIT, TMR_E, zero_v, zero_c);
                end
            end
            EV_TIMER_F: begin
                if (active) begin
                    phase_next     = PH_TERMINATED;
                    bundle.cnt     = CNT_W'(3);
                    bundle.acts[0] = mk_act(ACT_STOP, TMR_E, zero_v, zero_c);
                    bundle.acts[1] = mk_act(ACT_DELIVER, TMR_E, zero_v,
                                            TIMEOUT_CODE);
                    bundle.acts[2] = mk_act(ACT_RELEASE, TMR_E, zero_v, zero_c);
                end
            end
            EV_TIMER_K: begin
                if (phase_reg == PH_COMPLETED) begin
                    phase_next     = PH_TERMINATED;
                    bundle.cnt     = CNT_W'(1);
                    bundle.acts[0] = mk_act(ACT_RELEASE, TMR_E, zero_v, zero_c);
                end
            end
            default: begin
                bundle.cnt = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sipnict_emit.sv =====
// Result register: holds one event's action bundle and sends it one beat
// per action on the result channel. Depends on sipnict_pkg.
module sipnict_emit
    import sipnict_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  bundle_t              bundle,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ACT_W-1:0]     m_action,
    output logic [TID_W-1:0]     m_timer_id,
    output logic [TVAL_W-1:0]    m_timer_value,
    output logic [CODE_W-1:0]    m_status_code,
    output logic                 m_last
);

    logic              busy_reg, busy_next;
    logic [SEL_W-1:0]  idx_reg, idx_next;
    bundle_t           bnd_reg;
    act_t              cur;
    logic              pop;

    assign cur           = bnd_reg.acts[idx_reg];
    assign m_valid       = busy_reg;
    assign m_action      = cur.action;
    assign m_timer_id    = cur.timer_id;
    assign m_timer_value = cur.timer_value;
    assign m_status_code = cur.status_code;
    assign m_last        = (CNT_W'(idx_reg) + CNT_W'(1)) == bnd_reg.cnt;
    assign pop           = busy_reg && m_ready;
    assign can_load      = !busy_reg || (pop && m_last);

    // Advance through the bundle; a new load takes priority.
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (pop) begin
            if (m_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + SEL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Capture the bundle payload on load.
    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg <= bundle;
        end
    end

endmodule

// ===== hw/rtl/sip_client_non_invite_transaction_top.sv =====
// Top level of the SIP client non-INVITE transaction block.
// Depends on sipnict_pkg, sipnict_core and sipnict_emit.
//
// Each accepted event is held in an input register, decoded against the
// transaction phase once the result register can take it, and its run of
// zero to four actions is loaded into the result register, which sends one
// action per beat with m_last on the final one. An event that causes n
// actions occupies the result port for n beats, and the next event is not
// decoded until the last of those beats is taken; events that cause no
// action pass at one per cycle while the result register can load. The first
// result beat passes through the input register and then the result register.
// Timer values are T1, 64*T1 (22 bits), T4 and the timer E interval;
// configuration writes take effect at once and cfg_ready is always high.
module sip_client_non_invite_transaction_top
    import sipnict_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IVL_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [EV_W-1:0]      s_req_type,
    input  logic [CODE_W-1:0]    s_response_code,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ACT_W-1:0]     m_action,
    output logic [TID_W-1:0]     m_timer_id,
    output logic [TVAL_W-1:0]    m_timer_value,
    output logic [CODE_W-1:0]    m_status_code,
    output logic                 m_last
);

    logic [IVL_W-1:0]  t1_reg, t2_reg, t4_reg;
    logic              in_valid_reg;
    logic [EV_W-1:0]   req_type_reg;
    logic [CODE_W-1:0] response_code_reg;
    logic              take;
    logic              can_load;
    bundle_t           bundle;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= T1_RESET;
            t2_reg <= T2_RESET;
            t4_reg <= T4_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_T1:  t1_reg <= cfg_data;
                REG_T2:  t2_reg <= cfg_data;
                REG_T4:  t4_reg <= cfg_data;
                default: t1_reg <= t1_reg;
            endcase
        end
    end

    // Input register: refill when empty or whenever the held event is decoded.
    assign take    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg      <= s_req_type;
            response_code_reg <= s_response_code;
        end
    end

    sipnict_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .req_type      (req_type_reg),
        .response_code (response_code_reg),
        .t1            (t1_reg),
        .t2            (t2_reg),
        .t4            (t4_reg),
        .bundle        (bundle)
    );

    // Load only events that produce at least one action.
    sipnict_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (take && (bundle.cnt != '0)),
        .bundle        (bundle),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_timer_id    (m_timer_id),
        .m_timer_value (m_timer_value),
        .m_status_code (m_status_code),
        .m_last        (m_last)
    );

endmodule
